// ===== hdl/qeb_pkg.sv =====
// ----------------------------------------------------------------------------
// qeb_pkg
// Shared types, codes and the quadrature step table for the encoder block.
// ----------------------------------------------------------------------------
package qeb_pkg;

  // default widths and reset values
  localparam int unsigned HoldCountBitsDef = 16;
  localparam int unsigned CfgWidth         = 16;
  localparam logic [CfgWidth-1:0] LongPressTicksRst = 16'd500;

  // input event codes
  typedef enum logic [1:0] {
    OP_LEVEL_A = 2'd0,
    OP_LEVEL_B = 2'd1,
    OP_BUTTON  = 2'd2,
    OP_TICK    = 2'd3
  } op_e;

  // result event codes
  typedef enum logic [2:0] {
    EV_INC     = 3'd0,
    EV_DEC     = 3'd1,
    EV_PRESS   = 3'd2,
    EV_RELEASE = 3'd3,
    EV_LONG    = 3'd4
  } ev_e;

  // rotation direction of one phase step
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  // result of one processed item
  typedef struct packed {
    logic valid;
    ev_e  ev;
  } step_res_t;

  // old/new phase code to direction; no change and double steps give none
  function automatic dir_e step_dir(input logic [3:0] code);
    dir_e dir;
    case (code) inside
      4'b0010, 4'b0100, 4'b1011, 4'b1101: dir = DIR_UP;
      4'b0001, 4'b0111, 4'b1000, 4'b1110: dir = DIR_DOWN;
      default:                            dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

// ===== hdl/qeb_if.sv =====
// ----------------------------------------------------------------------------
// qeb_in_if / qeb_out_if
// Valid/ready channels for encoder events in and decoded results out.
// ----------------------------------------------------------------------------
interface qeb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic       level;

  modport source (output valid, output opcode, output level, input ready);
  modport sink   (input valid, input opcode, input level, output ready);
endinterface

interface qeb_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] event_res;

  modport source (output valid, output event_res, input ready);
  modport sink   (input valid, input event_res, output ready);
endinterface

// ===== hdl/quadrature_encoder_with_button_top.sv =====
// ----------------------------------------------------------------------------
// quadrature_encoder_with_button_top
// Quadrature encoder and push-button decoder with long-press detection.
// ----------------------------------------------------------------------------
// Takes one event per transfer (channel A level, channel B level, button level
// or a time tick) and gives at most one result (increase, decrease, pressed,
// released, long press). One item is taken every clock cycle while the output
// is not stalled; a result passes the input register, the single step stage
// and the result register, which lets the next item enter while a result
// waits to be taken. The user must write long_press_ticks through cfg_we_i and
// cfg_data_i only while the block is idle; the block does not enforce this.
module quadrature_encoder_with_button_top #(
  parameter int unsigned HoldCountBits = qeb_pkg::HoldCountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [qeb_pkg::CfgWidth-1:0] cfg_data_i,
  qeb_in_if.sink                       in_i,
  qeb_out_if.source                    out_o
);

  logic               in_valid_q;
  qeb_pkg::op_e       in_op_q;
  logic               in_level_q;
  logic               out_valid_q, out_valid_d;
  qeb_pkg::ev_e       out_ev_q;
  logic               adv;
  qeb_pkg::step_res_t res;

  // item leaves the input register when the result register can take it
  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_op_q    <= qeb_pkg::op_e'(in_i.opcode);
      in_level_q <= in_i.level;
    end
  end

  // step logic and state
  qeb_step #(
    .HoldCountBits(HoldCountBits)
  ) u_step (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .adv_i      (adv),
    .op_i       (in_op_q),
    .level_i    (in_level_q),
    .res_o      (res)
  );

  // result register
  always_comb begin
    if (adv) begin
      out_valid_d = res.valid;
    end else begin
      out_valid_d = out_valid_q && !out_o.ready;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && res.valid) begin
      out_ev_q <= res.ev;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.event_res = out_ev_q;

endmodule

// ===== hdl/qeb_step.sv =====
// ----------------------------------------------------------------------------
// qeb_step
// Decoder state, long-press register and the single-pass step logic.
// ----------------------------------------------------------------------------
module qeb_step #(
  parameter int unsigned HoldCountBits = qeb_pkg::HoldCountBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [qeb_pkg::CfgWidth-1:0]  cfg_data_i,
  input  logic                          adv_i,
  input  qeb_pkg::op_e                  op_i,
  input  logic                          level_i,
  output qeb_pkg::step_res_t            res_o
);

  localparam int unsigned LimW =
    (HoldCountBits > qeb_pkg::CfgWidth) ? HoldCountBits : qeb_pkg::CfgWidth;
  localparam logic [HoldCountBits-1:0] CntMax = {HoldCountBits{1'b1}};
  localparam logic [LimW-1:0] CntMaxExt = LimW'(CntMax);

  logic [qeb_pkg::CfgWidth-1:0] ticks_q;
  logic                         level_a_q, level_a_d;
  logic                         level_b_q, level_b_d;
  logic [1:0]                   phase_q, phase_d;
  logic                         button_q, button_d;
  logic                         armed_q, armed_d;
  logic [HoldCountBits-1:0]     count_q, count_d;

  logic [1:0]                   new_phase;
  qeb_pkg::dir_e                dir;
  logic [LimW-1:0]              limit_raw;
  logic [LimW-1:0]              limit;
  logic [HoldCountBits-1:0]     count_inc;
  logic                         pressed;
  logic                         rot;

  // long-press limit: zero acts as one, saturate at counter maximum
  always_comb begin
    limit_raw = (ticks_q == '0) ? LimW'(1) : LimW'(ticks_q);
    limit     = (limit_raw > CntMaxExt) ? CntMaxExt : limit_raw;
    count_inc = (count_q != CntMax) ? count_q + HoldCountBits'(1) : count_q;
    pressed   = ~level_i;
  end

  // phase lookup for a channel change
  always_comb begin
    new_phase = (op_i == qeb_pkg::OP_LEVEL_A) ? {level_i, level_b_q} : {level_a_q, level_i};
    dir       = qeb_pkg::step_dir({phase_q, new_phase});
  end

  // next state and result for one item
  always_comb begin
    level_a_d = level_a_q;
    level_b_d = level_b_q;
    phase_d   = phase_q;
    button_d  = button_q;
    armed_d   = armed_q;
    count_d   = count_q;
    res_o     = '{valid: 1'b0, ev: qeb_pkg::EV_INC};
    rot       = 1'b0;
    unique case (op_i)
      qeb_pkg::OP_LEVEL_A: rot = (level_i != level_a_q);
      qeb_pkg::OP_LEVEL_B: rot = (level_i != level_b_q);
      qeb_pkg::OP_BUTTON: begin
        if (pressed != button_q) begin
          button_d  = pressed;
          res_o.valid = 1'b1;
          if (pressed) begin
            armed_d  = 1'b1;
            count_d  = '0;
            res_o.ev = qeb_pkg::EV_PRESS;
          end else begin
            armed_d  = 1'b0;
            res_o.ev = qeb_pkg::EV_RELEASE;
          end
        end
      end
      qeb_pkg::OP_TICK: begin
        if (armed_q) begin
          count_d = count_inc;
          if (LimW'(count_inc) >= limit) begin
            armed_d     = 1'b0;
            res_o.valid = 1'b1;
            res_o.ev    = qeb_pkg::EV_LONG;
          end
        end
      end
      default: ;
    endcase
    if (rot) begin
      phase_d   = new_phase;
      level_a_d = new_phase[1];
      level_b_d = new_phase[0];
      if (dir == qeb_pkg::DIR_UP) begin
        res_o.valid = 1'b1;
        res_o.ev    = qeb_pkg::EV_INC;
      end else if (dir == qeb_pkg::DIR_DOWN) begin
        res_o.valid = 1'b1;
        res_o.ev    = qeb_pkg::EV_DEC;
      end
    end
  end

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= qeb_pkg::LongPressTicksRst;
    end else if (cfg_we_i) begin
      ticks_q <= cfg_data_i;
    end
  end

  // decoder state, updated when an item leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_a_q <= 1'b0;
      level_b_q <= 1'b0;
      phase_q   <= 2'b00;
      button_q  <= 1'b0;
      armed_q   <= 1'b0;
      count_q   <= '0;
    end else if (adv_i) begin
      level_a_q <= level_a_d;
      level_b_q <= level_b_d;
      phase_q   <= phase_d;
      button_q  <= button_d;
      armed_q   <= armed_d;
      count_q   <= count_d;
    end
  end

  // phase always mirrors the stored channel levels
  a_phase_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == {level_a_q, level_b_q})
    else $error("phase out of step with channel levels");

  // counter only runs while the button is held
  a_armed_pressed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> button_q)
    else $error("long-press counter armed while released");

  // long press only comes from an armed counter
  a_long_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_o.valid && res_o.ev == qeb_pkg::EV_LONG) |-> armed_q)
    else $error("long press without armed counter");

  // a press restarts the counter
  a_press_arms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && res_o.valid && res_o.ev == qeb_pkg::EV_PRESS) |=>
      (armed_q && count_q == '0))
    else $error("press did not arm and clear the counter");

endmodule
